### rtl/core/linked_node_queue_assert.svh
// ----------------------------------------------------------------------------
// linked_node_queue_assert
// assertion macros for the linked node queue, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef LINKED_NODE_QUEUE_ASSERT_SVH
`define LINKED_NODE_QUEUE_ASSERT_SVH

// same-cycle implication
`define LNQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("linked_node_queue assertion failed");

// next-cycle implication
`define LNQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("linked_node_queue assertion failed");

`endif

### rtl/core/lnq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnq_pkg
// codes, field widths and the result record of the linked node queue
// ----------------------------------------------------------------------------
package lnq_pkg;

  // field widths
  localparam int ACTION_W  = 2;
  localparam int NODE_ID_W = 4;
  localparam int VALUE_W   = 64;
  localparam int STATUS_W  = 2;

  // node numbers reachable through the node field
  localparam int NODE_SPACE = 1 << NODE_ID_W;

  // packed beat widths
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 80;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DEQUEUE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_QUEUED = 2'd2;

  // one result beat
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [NODE_ID_W-1:0] node;
    logic [VALUE_W-1:0]   value;
    logic                 empty;
    logic [NODE_ID_W-1:0] head;
  } res_t;

endpackage

### rtl/core/linked_node_queue.sv
`timescale 1ns / 1ps
// Path: an input beat is held in the input stage register, and its result beat is
// registered in the result register and leaves from there when out_tready is high.
// Throughput: one item per cycle; every action finishes in one pass through
// the link registers between the input stage and the result register; a
// result held by out_tready low stalls the input stage behind it.
// Reset: queue empty, no node queued, tail at node zero, both stages empty;
// link and payload stores are not cleared and are read only for queued nodes.
// ----------------------------------------------------------------------------
// linked_node_queue
// fifo over a fixed node pool kept as a doubly linked list, with a
// membership bit per node, explicit head and tail registers and one result
// beat per action
// ----------------------------------------------------------------------------
`include "linked_node_queue_assert.svh"

module linked_node_queue #(
  parameter int POOL_NODES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [lnq_pkg::IN_DATA_W-1:0]  in_tdata,   // node_id, item_value, zero pad
  input  logic [lnq_pkg::ACTION_W-1:0]   in_tuser,   // action
  // result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [lnq_pkg::OUT_DATA_W-1:0] out_tdata,  // out_node, out_value,
                                                      // queue_empty, head_node, pad
  output logic [lnq_pkg::STATUS_W-1:0]   out_tuser   // status
);

  // only nodes the node field can name need storage
  localparam int STORE_DEPTH = (POOL_NODES < lnq_pkg::NODE_SPACE) ? POOL_NODES
                                                                   : lnq_pkg::NODE_SPACE;
  localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int PAD_W = lnq_pkg::OUT_DATA_W - lnq_pkg::NODE_ID_W - lnq_pkg::VALUE_W
                         - 1 - lnq_pkg::NODE_ID_W;

  // input stage
  logic                            s1_vld_r;
  logic [lnq_pkg::ACTION_W-1:0]    s1_act_r;
  logic [lnq_pkg::NODE_ID_W-1:0]   s1_node_r;
  logic [lnq_pkg::VALUE_W-1:0]     s1_val_r;

  // result stage
  logic                            out_vld_r;
  lnq_pkg::res_t                   res_r;
  lnq_pkg::res_t                   res_nxt;

  // list state
  logic [IDX_W-1:0]                next_r [STORE_DEPTH];
  logic [IDX_W-1:0]                prev_r [STORE_DEPTH];
  logic [lnq_pkg::VALUE_W-1:0]     pay_r  [STORE_DEPTH];
  logic [STORE_DEPTH-1:0]          member_r, member_nxt;
  logic [IDX_W-1:0]                head_r, head_nxt;
  logic [IDX_W-1:0]                tail_r, tail_nxt;
  logic                            empty_r, empty_nxt;

  // store write ports
  logic                            nxt_we, prv_we, pay_we;
  logic [IDX_W-1:0]                nxt_waddr, nxt_wdata;
  logic [IDX_W-1:0]                prv_waddr, prv_wdata;

  // working signals
  logic                            advance;
  logic                            in_pool;
  logic [IDX_W-1:0]                idx;
  logic                            unlink_go;
  logic [IDX_W-1:0]                tgt;
  logic [IDX_W-1:0]                pred, after;

  // handshake
  assign advance    = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready  = !s1_vld_r || advance;
  assign out_tvalid = out_vld_r;
  assign out_tuser  = res_r.status;
  assign out_tdata  = {{PAD_W{1'b0}}, res_r.head, res_r.empty, res_r.value, res_r.node};

  assign idx     = s1_node_r[IDX_W-1:0];
  assign in_pool = (32'(s1_node_r) < 32'(POOL_NODES));
  assign pred    = prev_r[tgt];
  assign after   = next_r[tgt];

  // action decode and list update
  always_comb begin
    res_nxt.status = lnq_pkg::ST_MISS;
    res_nxt.node   = s1_node_r;
    res_nxt.value  = '0;
    member_nxt     = member_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    empty_nxt      = empty_r;
    nxt_we         = 1'b0;
    prv_we         = 1'b0;
    pay_we         = 1'b0;
    nxt_waddr      = tail_r;
    nxt_wdata      = idx;
    prv_waddr      = idx;
    prv_wdata      = tail_r;
    unlink_go      = 1'b0;
    tgt            = head_r;

    case (s1_act_r)
      lnq_pkg::ACT_ENQUEUE: begin
        if (in_pool && member_r[idx]) begin
          res_nxt.status = lnq_pkg::ST_QUEUED;
        end else if (in_pool) begin
          // link behind the tail; tail-to-head links are implied by head and tail
          if (empty_r) begin
            head_nxt = idx;
          end else begin
            nxt_we = 1'b1;
            prv_we = 1'b1;
          end
          tail_nxt        = idx;
          empty_nxt       = 1'b0;
          pay_we          = 1'b1;
          member_nxt[idx] = 1'b1;
          res_nxt.status  = lnq_pkg::ST_DONE;
        end
      end
      lnq_pkg::ACT_DEQUEUE: begin
        if (empty_r) begin
          res_nxt.node = '0;
        end else begin
          unlink_go      = 1'b1;
          tgt            = head_r;
          res_nxt.node   = lnq_pkg::NODE_ID_W'(head_r);
          res_nxt.status = lnq_pkg::ST_DONE;
        end
      end
      lnq_pkg::ACT_REMOVE: begin
        if (in_pool && !empty_r && member_r[idx]) begin
          unlink_go      = 1'b1;
          tgt            = idx;
          res_nxt.status = lnq_pkg::ST_DONE;
        end
      end
      default: begin
        res_nxt.status = lnq_pkg::ST_MISS;
      end
    endcase

    // unlink one queued node
    if (unlink_go) begin
      res_nxt.value   = pay_r[tgt];
      member_nxt[tgt] = 1'b0;
      if (head_r == tail_r) begin
        empty_nxt = 1'b1;
      end else if (tgt == head_r) begin
        head_nxt = after;
      end else if (tgt == tail_r) begin
        tail_nxt = pred;
      end else begin
        nxt_we    = 1'b1;
        nxt_waddr = pred;
        nxt_wdata = after;
        prv_we    = 1'b1;
        prv_waddr = after;
        prv_wdata = pred;
      end
    end

    res_nxt.empty = empty_nxt;
    res_nxt.head  = empty_nxt ? '0 : lnq_pkg::NODE_ID_W'(head_nxt);
  end

  // input stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_act_r  <= in_tuser;
      s1_node_r <= in_tdata[lnq_pkg::NODE_ID_W-1:0];
      s1_val_r  <= in_tdata[lnq_pkg::NODE_ID_W +: lnq_pkg::VALUE_W];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  // queue control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      member_r <= '0;
      head_r   <= '0;
      tail_r   <= '0;
      empty_r  <= 1'b1;
    end else if (advance) begin
      member_r <= member_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      empty_r  <= empty_nxt;
    end
  end

  // link and payload stores
  always_ff @(posedge clk) begin
    if (advance && nxt_we) begin
      next_r[nxt_waddr] <= nxt_wdata;
    end
    if (advance && prv_we) begin
      prev_r[prv_waddr] <= prv_wdata;
    end
    if (advance && pay_we) begin
      pay_r[idx] <= s1_val_r;
    end
  end

  // an empty queue holds no member
  `LNQ_ASSERT_IMPL(a_empty_no_members, empty_r, member_r == '0)
  // head and tail of a filled queue are queued nodes
  `LNQ_ASSERT_IMPL(a_ends_queued, !empty_r, member_r[head_r] && member_r[tail_r])
  // a dequeue that hits takes its head out of the queue
  `LNQ_ASSERT_NEXT(a_dequeue_clears, advance && !empty_r &&
                   s1_act_r == lnq_pkg::ACT_DEQUEUE, !member_r[$past(head_r)])

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the linked node queue: drives enqueue, dequeue,
// remove and unused-code beats with random idling on both channels, predicts
// each result beat from a local copy of the list and compares every field in order
// ----------------------------------------------------------------------------
module testbench;

  localparam int NODES     = 16;
  localparam int CYCLE_CAP = 200000;
  localparam int NW        = lnq_pkg::NODE_ID_W;
  localparam int VW        = lnq_pkg::VALUE_W;
  localparam logic [lnq_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [lnq_pkg::IN_DATA_W-1:0]  in_tdata   = '0;  // node_id, item_value, pad
  logic [lnq_pkg::ACTION_W-1:0]   in_tuser   = '0;  // action
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [lnq_pkg::OUT_DATA_W-1:0] out_tdata;        // out_node, out_value, queue_empty,
                                                    // head_node, pad
  logic [lnq_pkg::STATUS_W-1:0]   out_tuser;        // status

  // local copy of the list
  logic [NW-1:0] link_next [NODES];
  logic [NW-1:0] link_prev [NODES];
  logic [VW-1:0] node_value[NODES];
  logic          queued    [NODES];
  logic [NW-1:0] tail_at;
  logic          list_empty;

  lnq_pkg::res_t pending_results[$];
  int     error_count  = 0;
  int     cycle_count  = 0;
  bit     send_steady  = 1'b0;
  bit     drain_steady = 1'b0;

  linked_node_queue i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic int draw_gap(bit steady);
    if (steady) return 0;
    return $urandom_range(0, 10);
  endfunction

  // take a queued node out of the local list
  function automatic void unlink_local(logic [NW-1:0] n);
    logic [NW-1:0] prior;
    logic [NW-1:0] later;
    if (link_next[n] == n) begin
      list_empty = 1'b1;
    end else begin
      prior = link_prev[n];
      later = link_next[n];
      link_next[prior] = later;
      link_prev[later] = prior;
      if (n == tail_at) tail_at = prior;
    end
    queued[n] = 1'b0;
  endfunction

  // apply one action to the local list and return the result beat it causes
  function automatic lnq_pkg::res_t queue_step(logic [lnq_pkg::ACTION_W-1:0] act,
                                               logic [NW-1:0] n, logic [VW-1:0] v);
    lnq_pkg::res_t r;
    logic [NW-1:0] front;
    r.status = lnq_pkg::ST_MISS;
    r.node   = n;
    r.value  = '0;
    case (act)
      lnq_pkg::ACT_ENQUEUE: begin
        if (queued[n]) begin
          r.status = lnq_pkg::ST_QUEUED;
        end else begin
          if (list_empty) begin
            link_next[n] = n;
            link_prev[n] = n;
            list_empty   = 1'b0;
          end else begin
            front              = link_next[tail_at];
            link_next[n]       = front;
            link_prev[n]       = tail_at;
            link_prev[front]   = n;
            link_next[tail_at] = n;
          end
          tail_at       = n;
          node_value[n] = v;
          queued[n]     = 1'b1;
          r.status      = lnq_pkg::ST_DONE;
        end
      end
      lnq_pkg::ACT_DEQUEUE: begin
        if (list_empty) begin
          r.node = '0;
        end else begin
          front    = link_next[tail_at];
          r.node   = front;
          r.value  = node_value[front];
          unlink_local(front);
          r.status = lnq_pkg::ST_DONE;
        end
      end
      lnq_pkg::ACT_REMOVE: begin
        if (!list_empty && queued[n]) begin
          r.value  = node_value[n];
          unlink_local(n);
          r.status = lnq_pkg::ST_DONE;
        end
      end
      default: ;
    endcase
    r.empty = list_empty;
    r.head  = list_empty ? '0 : link_next[tail_at];
    return r;
  endfunction

  // send one beat after a random gap, record its result once taken
  task automatic send_item(logic [lnq_pkg::ACTION_W-1:0] act, logic [NW-1:0] n,
                           logic [VW-1:0] v);
    int gap;
    bit taken;
    gap = draw_gap(send_steady);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {{(lnq_pkg::IN_DATA_W - VW - NW){1'b0}}, v, n};
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
    pending_results.push_back(queue_step(act, n, v));
  endtask

  // hold the input until every result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // a random node number in the pool
  function automatic logic [NW-1:0] any_node();
    return NW'($urandom_range(0, NODES - 1));
  endfunction

  // a node whose membership matches the wish, or any node if none does
  function automatic logic [NW-1:0] pick_node(bit want_queued);
    int start;
    start = $urandom_range(0, NODES - 1);
    for (int k = 0; k < NODES; k++)
      if (queued[(start + k) % NODES] == want_queued) return NW'((start + k) % NODES);
    return NW'(start);
  endfunction

  function automatic logic [VW-1:0] draw_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // one random action; filling leans toward enqueue, draining toward removal
  task automatic random_item(bit filling);
    int            roll;
    int            enq_top;
    int            deq_top;
    logic [NW-1:0] n;
    roll    = $urandom_range(0, 99);
    enq_top = filling ? 68 : 33;
    deq_top = filling ? 84 : 66;
    if (roll < 3) begin
      send_item(ACT_UNUSED, any_node(), draw_value());
    end else if (roll < enq_top) begin
      n = ($urandom_range(0, 9) < 8) ? pick_node(1'b0) : any_node();
      send_item(lnq_pkg::ACT_ENQUEUE, n, draw_value());
    end else if (roll < deq_top) begin
      send_item(lnq_pkg::ACT_DEQUEUE, any_node(), draw_value());
    end else begin
      n = ($urandom_range(0, 9) < 8) ? pick_node(1'b1) : any_node();
      send_item(lnq_pkg::ACT_REMOVE, n, draw_value());
    end
  endtask

  // result side: random stalls, one draw per beat
  initial begin
    int  stall;
    bit  taken;
    forever begin
      stall = draw_gap(drain_steady);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do begin
        @(negedge clk);
        taken = out_tvalid;
        @(posedge clk);
      end while (!taken);
    end
  end

  // compare each result beat with the oldest prediction
  always @(negedge clk) begin
    lnq_pkg::res_t want;
    lnq_pkg::res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      got.node   = out_tdata[NW-1:0];
      got.value  = out_tdata[NW +: VW];
      got.empty  = out_tdata[NW + VW];
      got.head   = out_tdata[NW + VW + 1 +: NW];
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: status %0d node %0d",
               got.status, got.node);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          error_count++;
        end
        if (got.node !== want.node) begin
          $error("out_node: expected %0d, actual %0d", want.node, got.node);
          error_count++;
        end
        if (got.value !== want.value) begin
          $error("out_value: expected %h, actual %h", want.value, got.value);
          error_count++;
        end
        if (got.empty !== want.empty) begin
          $error("queue_empty: expected %0d, actual %0d", want.empty, got.empty);
          error_count++;
        end
        if (got.head !== want.head) begin
          $error("head_node: expected %0d, actual %0d", want.head, got.head);
          error_count++;
        end
      end
    end
  end

  // extremes, every action and the corner cases of the list
  task automatic test_directed();
    send_item(lnq_pkg::ACT_DEQUEUE, 4'd9, '1);                    // dequeue on empty
    send_item(lnq_pkg::ACT_REMOVE, 4'd5, '0);                     // remove on empty
    send_item(lnq_pkg::ACT_ENQUEUE, 4'd0, '0);
    send_item(lnq_pkg::ACT_REMOVE, 4'd0, '1);                     // remove the only node
    send_item(lnq_pkg::ACT_ENQUEUE, 4'd15, '1);
    send_item(lnq_pkg::ACT_ENQUEUE, 4'd0, 64'h5555_aaaa_0f0f_f0f0);
    send_item(lnq_pkg::ACT_ENQUEUE, 4'd15, 64'h1234_5678_9abc_def0); // already queued
    send_item(lnq_pkg::ACT_ENQUEUE, 4'd7, 64'haaaa_5555_f0f0_0f0f);
    send_item(lnq_pkg::ACT_ENQUEUE, 4'd3, 64'h8000_0000_0000_0001);
    send_item(lnq_pkg::ACT_REMOVE, 4'd3, '0);                     // remove the tail
    send_item(lnq_pkg::ACT_REMOVE, 4'd0, '0);                     // remove from the middle
    send_item(lnq_pkg::ACT_REMOVE, 4'd15, '0);                    // remove the head
    send_item(lnq_pkg::ACT_REMOVE, 4'd11, '0);                    // node not queued
    send_item(ACT_UNUSED, 4'd6, '1);
    send_item(lnq_pkg::ACT_ENQUEUE, 4'd12, 64'h7fff_ffff_ffff_fffe);
    send_item(lnq_pkg::ACT_DEQUEUE, 4'd0, '0);
    send_item(lnq_pkg::ACT_DEQUEUE, 4'd0, '0);
    send_item(lnq_pkg::ACT_DEQUEUE, 4'd0, '0);                    // dequeue until empty
    wait_drained();
  endtask

  // back-to-back beats with no idling on either side
  task automatic test_streaming();
    send_steady  = 1'b1;
    drain_steady = 1'b1;
    for (int k = 0; k < 60; k++) random_item(k < 30);
    wait_drained();
    send_steady  = 1'b0;
    drain_steady = 1'b0;
  endtask

  // fill and drain phases, most with random idling, pausing for results after some of them
  task automatic test_fill_drain();
    for (int phase = 0; phase < 8; phase++) begin
      send_steady  = (phase == 5);
      drain_steady = (phase == 2);
      for (int k = 0; k < 42; k++) random_item(phase % 2 == 0);
      if (phase % 3 == 2) wait_drained();
    end
    send_steady  = 1'b0;
    drain_steady = 1'b0;
  endtask

  initial begin
    list_empty = 1'b1;
    tail_at    = '0;
    for (int k = 0; k < NODES; k++) queued[k] = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_streaming();
    test_fill_drain();
    wait_drained();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/lnq_pkg.sv
rtl/core/linked_node_queue.sv
tb/sv/testbench.sv
